/* src/pab_pkg.sv */
package pab_pkg;

    localparam int NUM_CH = 3;

    typedef logic [7:0] chan_t;

    localparam logic CMD_BLEND = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] MODE_PALETTE = 2'd0;
    localparam logic [1:0] MODE_RGB     = 2'd1;
    localparam logic [1:0] MODE_RGBA    = 2'd2;

    localparam logic REG_PIXEL_MODE     = 1'b0;
    localparam logic REG_GLOBAL_OPACITY = 1'b1;

    localparam logic [1:0] PIXEL_MODE_RST     = MODE_RGB;
    localparam chan_t      GLOBAL_OPACITY_RST = 8'd255;

    localparam logic [7:0] ROUND_BIAS = 8'd127;
    localparam chan_t      FULL_WEIGHT = 8'd255;

    // Quotient of x / 255 for x <= 255*255+127. Estimate x*257/65536, which is low
    // by at most one, then correct with a single compare.
    function automatic chan_t div255(input logic [15:0] x);
        logic [16:0] sum;
        logic [8:0]  q_est;
        logic [17:0] rem;
        logic [8:0]  q;
        sum   = {1'b0, x} + {9'd0, x[15:8]};
        q_est = sum[16:8];
        rem   = {2'b00, x} + {9'd0, q_est} - {1'b0, q_est, 8'd0};
        q     = q_est + {8'd0, (rem >= 18'd255)};
        return q[7:0];
    endfunction

endpackage

/* src/pab_palette.sv */
module pab_palette #(
    parameter int ENTRIES = 256
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [7:0]          wr_index,
    input  logic [23:0]         wr_data,
    input  logic                rd_en,
    input  logic [7:0]          rd_index,
    output logic [23:0]         rd_data
);
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [23:0] mem [ENTRIES];
    logic [23:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_index[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_index[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/pab_lane.sv */
module pab_lane (
    input  logic         aclk,
    input  logic         load,
    input  pab_pkg::chan_t src,
    input  pab_pkg::chan_t dst,
    input  pab_pkg::chan_t weight,
    output pab_pkg::chan_t result
);
    import pab_pkg::*;

    logic signed [17:0] num_reg;
    logic signed [17:0] num_next;
    chan_t              src_reg;
    chan_t              dst_reg;
    logic               wzero_reg;
    logic               wfull_reg;

    logic signed [8:0]  diff;
    logic [17:0]        mag;
    chan_t              quot;
    chan_t              mixed;

    assign diff     = $signed({1'b0, src}) - $signed({1'b0, dst});
    assign num_next = 18'(diff) * 18'($signed({1'b0, weight})) + 18'sd127;

    always_ff @(posedge aclk) begin
        if (load) begin
            num_reg   <= num_next;
            src_reg   <= src;
            dst_reg   <= dst;
            wzero_reg <= (weight == 8'd0);
            wfull_reg <= (weight == FULL_WEIGHT);
        end
    end

    // Truncate toward zero: divide the magnitude, then restore the sign.
    assign mag   = num_reg[17] ? 18'(-num_reg) : 18'(num_reg);
    assign quot  = div255(mag[15:0]);
    assign mixed = num_reg[17] ? dst_reg - quot : dst_reg + quot;

    always_comb begin
        if (wzero_reg) begin
            result = dst_reg;
        end else if (wfull_reg) begin
            result = src_reg;
        end else begin
            result = mixed;
        end
    end

endmodule

/* src/pixel_alpha_blend.sv */
// Channel  | Direction | Handshake            | Payload
// s_       | in        | s_valid / s_ready    | s_cmd, s_pal_index, s_src_c0..2, s_src_alpha,
//          |           |                      | s_dst_c0..2
// m_       | out       | m_valid / m_ready    | m_out_c0..2
// cfg_     | in        | cfg_wr_en            | cfg_addr, cfg_wdata
//
// One transaction per clock while m_ready does not stall the pipeline. A blend result
// reaches m_ through four register stages: palette read with alpha times opacity,
// weight divide, lane multiply, lane divide into the output register.
// Palette writes finish at acceptance and give no result.
// Reset clears the stage valids and the two registers; the palette is not cleared.
// Every stage holds only while the stage after it is full and held, so a stall on m_ready
// lets empty stages fill first and holds s_ready low only once every stage is full.
module pixel_alpha_blend #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic           cfg_addr,
    input  logic [7:0]     cfg_wdata,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_cmd,
    input  logic [7:0]     s_pal_index,
    input  pab_pkg::chan_t s_src_c0,
    input  pab_pkg::chan_t s_src_c1,
    input  pab_pkg::chan_t s_src_c2,
    input  pab_pkg::chan_t s_src_alpha,
    input  pab_pkg::chan_t s_dst_c0,
    input  pab_pkg::chan_t s_dst_c1,
    input  pab_pkg::chan_t s_dst_c2,
    output logic           m_valid,
    input  logic           m_ready,
    output pab_pkg::chan_t m_out_c0,
    output pab_pkg::chan_t m_out_c1,
    output pab_pkg::chan_t m_out_c2
);
    import pab_pkg::*;

    logic [1:0]  pixel_mode_reg;
    chan_t       global_opacity_reg;

    logic        v1_reg, v2_reg, v3_reg, vo_reg;
    logic        rdy1, rdy2, rdy3, rdyo;

    logic        idx_ok;
    logic        s_acc;
    logic [23:0] pal_rd;

    logic        pal_sel1_reg;
    logic        idx_ok1_reg;
    logic        rgba1_reg;
    logic [15:0] prod1_reg;
    chan_t [NUM_CH-1:0] src1_reg;
    chan_t [NUM_CH-1:0] dst1_reg;

    chan_t [NUM_CH-1:0] src2_reg;
    chan_t [NUM_CH-1:0] src2_next;
    chan_t [NUM_CH-1:0] dst2_reg;
    chan_t              w2_reg;
    chan_t              w2_next;

    chan_t [NUM_CH-1:0] lane_res;
    chan_t [NUM_CH-1:0] out_reg;

    assign idx_ok = ({24'd0, s_pal_index} < 32'(PALETTE_ENTRIES));
    assign s_acc  = s_valid && s_ready;

    assign rdyo    = !vo_reg || m_ready;
    assign rdy3    = !v3_reg || rdyo;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_mode_reg     <= PIXEL_MODE_RST;
            global_opacity_reg <= GLOBAL_OPACITY_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_PIXEL_MODE:     pixel_mode_reg     <= cfg_wdata[1:0];
                REG_GLOBAL_OPACITY: global_opacity_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid && (s_cmd == CMD_BLEND);
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdyo) vo_reg <= v3_reg;
        end
    end

    pab_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .aclk     (aclk),
        .wr_en    (s_acc && (s_cmd == CMD_WRITE) && idx_ok),
        .wr_index (s_pal_index),
        .wr_data  ({s_src_c2, s_src_c1, s_src_c0}),
        .rd_en    (rdy1),
        .rd_index (s_pal_index),
        .rd_data  (pal_rd)
    );

    // Stage 1: capture the transaction and form alpha times opacity.
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            pal_sel1_reg <= (pixel_mode_reg == MODE_PALETTE);
            idx_ok1_reg  <= idx_ok;
            rgba1_reg    <= pixel_mode_reg[1];
            prod1_reg    <= 16'(s_src_alpha * global_opacity_reg);
            src1_reg     <= {s_src_c2, s_src_c1, s_src_c0};
            dst1_reg     <= {s_dst_c2, s_dst_c1, s_dst_c0};
        end
    end

    // Stage 2: pick the source colour and the effective weight.
    always_comb begin
        if (!pal_sel1_reg) begin
            src2_next = src1_reg;
        end else if (idx_ok1_reg) begin
            src2_next = pal_rd;
        end else begin
            src2_next = '0;
        end
        w2_next = rgba1_reg ? div255(prod1_reg + {8'd0, ROUND_BIAS}) : global_opacity_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            src2_reg <= src2_next;
            dst2_reg <= dst1_reg;
            w2_reg   <= w2_next;
        end
    end

    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        pab_lane u_lane (
            .aclk   (aclk),
            .load   (rdy3),
            .src    (src2_reg[ch]),
            .dst    (dst2_reg[ch]),
            .weight (w2_reg),
            .result (lane_res[ch])
        );
    end

    // Merge the lane results into the output register.
    always_ff @(posedge aclk) begin
        if (rdyo) begin
            out_reg <= lane_res;
        end
    end

    assign m_valid  = vo_reg;
    assign m_out_c0 = out_reg[0];
    assign m_out_c1 = out_reg[1];
    assign m_out_c2 = out_reg[2];

`ifndef NO_ASSERTIONS
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_cmd == CMD_WRITE)) |=> !v1_reg)
        else $error("palette write entered the blend pipeline");

    a_blend_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_cmd == CMD_BLEND)) |=> v1_reg)
        else $error("accepted blend lost at stage 1");

    a_stage3_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !rdyo) |=> v3_reg)
        else $error("stage 3 dropped a held transaction");

    a_stage2_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && rdy3) |=> v3_reg)
        else $error("stage 2 transaction did not reach the lanes");
`endif

endmodule

/* sim/pixel_alpha_blend_tb.sv */
module pixel_alpha_blend_tb;
    import pab_pkg::*;

    // Mode 3 has no meaning of its own and must behave as RGBA.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int N_DIRECTED = 23;
    localparam int N_PHASES = 10;
    localparam int PHASE_ITEMS = 80;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  idx;
        logic [23:0] src;    // {c0, c1, c2}
        logic [7:0]  alpha;
        logic [23:0] dst;
    } pix_item_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  opac;
        logic        cmd;
        logic [7:0]  idx;
        logic [23:0] src;
        logic [7:0]  alpha;
        logic [23:0] dst;
        logic        typed;  // want holds the known answer
        logic [23:0] want;
    } dir_row_t;

    localparam dir_row_t DIRECTED [0:N_DIRECTED-1] = '{
        '{MODE_RGB,     8'hff, CMD_BLEND, 8'h00, 24'hff0080, 8'h00, 24'h00ff12, 1'b1, 24'hff0080},
        '{MODE_RGB,     8'hff, CMD_BLEND, 8'hff, 24'h000000, 8'hff, 24'hffffff, 1'b1, 24'h000000},
        '{MODE_RGB,     8'hff, CMD_WRITE, 8'h00, 24'h112233, 8'h00, 24'h000000, 1'b0, 24'h0},
        '{MODE_RGB,     8'hff, CMD_WRITE, 8'hff, 24'hffeedd, 8'h00, 24'h000000, 1'b0, 24'h0},
        '{MODE_RGB,     8'hff, CMD_WRITE, 8'h5a, 24'ha5c300, 8'h00, 24'h000000, 1'b0, 24'h0},
        '{MODE_RGB,     8'h00, CMD_BLEND, 8'h33, 24'hffffff, 8'hff, 24'h123456, 1'b1, 24'h123456},
        '{MODE_RGB,     8'h80, CMD_BLEND, 8'h00, 24'hff00ff, 8'h80, 24'h00ff10, 1'b0, 24'h0},
        '{MODE_RGB,     8'h01, CMD_BLEND, 8'h00, 24'hff0000, 8'h00, 24'h00ff00, 1'b0, 24'h0},
        '{MODE_RGB,     8'hfe, CMD_BLEND, 8'h00, 24'h00ff80, 8'h00, 24'hff007f, 1'b0, 24'h0},
        '{MODE_PALETTE, 8'hff, CMD_BLEND, 8'h00, 24'h000000, 8'h00, 24'hffffff, 1'b1, 24'h112233},
        '{MODE_PALETTE, 8'hff, CMD_BLEND, 8'hff, 24'h000000, 8'h00, 24'h000000, 1'b1, 24'hffeedd},
        '{MODE_PALETTE, 8'h64, CMD_BLEND, 8'h5a, 24'hffffff, 8'hff, 24'h0000ff, 1'b0, 24'h0},
        '{MODE_PALETTE, 8'h64, CMD_WRITE, 8'h5a, 24'h010203, 8'h00, 24'h000000, 1'b0, 24'h0},
        '{MODE_PALETTE, 8'h64, CMD_BLEND, 8'h5a, 24'h000000, 8'h00, 24'hf0e0d0, 1'b0, 24'h0},
        '{MODE_PALETTE, 8'h00, CMD_BLEND, 8'hff, 24'h000000, 8'h00, 24'habcdef, 1'b1, 24'habcdef},
        '{MODE_RGBA,    8'hff, CMD_BLEND, 8'h00, 24'hffffff, 8'h00, 24'h102030, 1'b1, 24'h102030},
        '{MODE_RGBA,    8'hff, CMD_BLEND, 8'h00, 24'hffffff, 8'hff, 24'h102030, 1'b1, 24'hffffff},
        '{MODE_RGBA,    8'hff, CMD_BLEND, 8'h00, 24'hff00ff, 8'h80, 24'h00ff00, 1'b0, 24'h0},
        '{MODE_RGBA,    8'h00, CMD_BLEND, 8'h00, 24'hffffff, 8'hff, 24'h405060, 1'b1, 24'h405060},
        '{MODE_RGBA,    8'h01, CMD_BLEND, 8'h00, 24'hffffff, 8'h01, 24'h000000, 1'b0, 24'h0},
        '{MODE_SPARE,   8'hc8, CMD_BLEND, 8'h00, 24'ha0b0c0, 8'h4d, 24'h102030, 1'b0, 24'h0},
        '{MODE_SPARE,   8'hc8, CMD_BLEND, 8'h00, 24'ha0b0c0, 8'h00, 24'h102030, 1'b1, 24'h102030},
        '{MODE_SPARE,   8'hc8, CMD_WRITE, 8'h80, 24'h7f7f7f, 8'h00, 24'h000000, 1'b0, 24'h0}
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_addr = REG_PIXEL_MODE;
    logic [7:0] cfg_wdata = 8'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_cmd = CMD_BLEND;
    logic [7:0] s_pal_index = 8'd0;
    chan_t      s_src_c0 = 8'd0;
    chan_t      s_src_c1 = 8'd0;
    chan_t      s_src_c2 = 8'd0;
    chan_t      s_src_alpha = 8'd0;
    chan_t      s_dst_c0 = 8'd0;
    chan_t      s_dst_c1 = 8'd0;
    chan_t      s_dst_c2 = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    chan_t      m_out_c0;
    chan_t      m_out_c1;
    chan_t      m_out_c2;

    // Shadow of the block's registers and colour table.
    logic [1:0]  mode_sh = PIXEL_MODE_RST;
    logic [7:0]  opac_sh = GLOBAL_OPACITY_RST;
    logic [23:0] palette_sh [0:255];
    bit          pal_written [0:255];
    logic [7:0]  written_list [$];
    logic [7:0]  last_written = 8'd0;

    logic [23:0] blend_expect_q [$];
    int          err_count = 0;
    bit          no_idle = 1'b0;
    int          burst_left = 0;
    int unsigned stall_tick = 0;
    logic [7:0]  stall_pat = 8'hff;

    pixel_alpha_blend dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_pal_index (s_pal_index),
        .s_src_c0    (s_src_c0),
        .s_src_c1    (s_src_c1),
        .s_src_c2    (s_src_c2),
        .s_src_alpha (s_src_alpha),
        .s_dst_c0    (s_dst_c0),
        .s_dst_c1    (s_dst_c1),
        .s_dst_c2    (s_dst_c2),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_c0    (m_out_c0),
        .m_out_c1    (m_out_c1),
        .m_out_c2    (m_out_c2)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [7:0] mix_lane(input logic [7:0] s, input logic [7:0] d,
                                            input int w);
        int diff;
        int q;
        diff = int'(s) - int'(d);
        // SV division truncates toward zero, as the blend rule requires
        q = (diff * w + 127) / 255;
        return 8'(int'(d) + q);
    endfunction

    function automatic logic [23:0] blended_pixel(input pix_item_t it);
        logic [23:0] src;
        logic [23:0] res;
        int w;
        src = it.src;
        if (mode_sh == MODE_PALETTE) begin
            src = palette_sh[it.idx];
        end
        if (mode_sh == MODE_RGBA || mode_sh == MODE_SPARE) begin
            w = (int'(it.alpha) * int'(opac_sh) + 127) / 255;
        end else begin
            w = int'(opac_sh);
        end
        for (int i = 0; i < NUM_CH; i++) begin
            if (w == 0) begin
                res[i*8 +: 8] = it.dst[i*8 +: 8];
            end else if (w == 255) begin
                res[i*8 +: 8] = src[i*8 +: 8];
            end else begin
                res[i*8 +: 8] = mix_lane(src[i*8 +: 8], it.dst[i*8 +: 8], w);
            end
        end
        return res;
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pix_item_t random_item();
        pix_item_t it;
        int pick;
        it.src = {rand_chan(), rand_chan(), rand_chan()};
        it.alpha = rand_chan();
        it.dst = {rand_chan(), rand_chan(), rand_chan()};
        it.idx = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (mode_sh == MODE_PALETTE) begin
            if (pick < 30) begin
                it.cmd = CMD_WRITE;
            end else begin
                it.cmd = CMD_BLEND;
                // read only written entries; favor the newest to hit write-then-read
                if (pick < 45) begin
                    it.idx = last_written;
                end else begin
                    it.idx = written_list[$urandom_range(0, written_list.size() - 1)];
                end
            end
        end else begin
            it.cmd = (pick < 10) ? CMD_WRITE : CMD_BLEND;
        end
        return it;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_result();
        logic [23:0] want;
        if (blend_expect_q.size() == 0) begin
            flag_error($sformatf("unexpected pixel %h %h %h", m_out_c0, m_out_c1, m_out_c2));
        end else begin
            want = blend_expect_q.pop_front();
            if (m_out_c0 !== want[23:16]) begin
                flag_error($sformatf("out_c0 got %h want %h", m_out_c0, want[23:16]));
            end
            if (m_out_c1 !== want[15:8]) begin
                flag_error($sformatf("out_c1 got %h want %h", m_out_c1, want[15:8]));
            end
            if (m_out_c2 !== want[7:0]) begin
                flag_error($sformatf("out_c2 got %h want %h", m_out_c2, want[7:0]));
            end
        end
    endtask

    // Present one transaction and hold it until taken; then update the shadow state.
    task automatic push_item(input pix_item_t it, input logic typed, input logic [23:0] want);
        s_valid     <= 1'b1;
        s_cmd       <= it.cmd;
        s_pal_index <= it.idx;
        s_src_c0    <= it.src[23:16];
        s_src_c1    <= it.src[15:8];
        s_src_c2    <= it.src[7:0];
        s_src_alpha <= it.alpha;
        s_dst_c0    <= it.dst[23:16];
        s_dst_c1    <= it.dst[15:8];
        s_dst_c2    <= it.dst[7:0];
        do @(posedge aclk); while (!s_ready);
        if (it.cmd == CMD_WRITE) begin
            palette_sh[it.idx] = it.src;
            if (!pal_written[it.idx]) begin
                pal_written[it.idx] = 1'b1;
                written_list.push_back(it.idx);
            end
            last_written = it.idx;
        end else begin
            blend_expect_q.push_back(typed ? want : blended_pixel(it));
        end
    endtask

    task automatic pace_sender();
        int gap;
        if (!no_idle) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
        end
    endtask

    // Drain, let palette writes settle, then write both registers.
    task automatic apply_config(input logic [1:0] mode, input logic [7:0] opac);
        s_valid <= 1'b0;
        while (blend_expect_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_PIXEL_MODE;
        cfg_wdata <= {6'd0, mode};
        @(posedge aclk);
        cfg_addr  <= REG_GLOBAL_OPACITY;
        cfg_wdata <= opac;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mode_sh = mode;
        opac_sh = opac;
    endtask

    always @(posedge aclk) begin
        if (stall_tick % 64 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pat = 8'hff;
                1: stall_pat = 8'h01;
                default: stall_pat = 8'($urandom) | 8'h01;
            endcase
        end
        m_ready <= no_idle || stall_pat[stall_tick % 8];
        stall_tick++;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_result();
        end
    end

    initial begin
        dir_row_t  row;
        logic [1:0] mode;
        logic [7:0] opac;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first rows run on the reset register values
        for (int k = 0; k < N_DIRECTED; k++) begin
            row = DIRECTED[k];
            if (row.mode != mode_sh || row.opac != opac_sh) begin
                apply_config(row.mode, row.opac);
            end
            push_item('{row.cmd, row.idx, row.src, row.alpha, row.dst}, row.typed, row.want);
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            mode = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
            case (phase)
                0: opac = 8'hff;
                1: opac = 8'h00;
                3: opac = 8'h01;
                4: opac = 8'hfe;
                default: opac = 8'($urandom);
            endcase
            apply_config(mode, opac);
            no_idle = (phase == 2);
            repeat (PHASE_ITEMS) begin
                push_item(random_item(), 1'b0, 24'd0);
                pace_sender();
            end
        end
        no_idle = 1'b0;
        s_valid <= 1'b0;

        while (blend_expect_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (err_count == 0) begin
            $display("pixel_alpha_blend_tb passed");
        end else begin
            $display("pixel_alpha_blend_tb failed");
        end
        $finish;
    end

    initial begin
        #(12 * 400_000);
        $display("pixel_alpha_blend_tb failed");
        $finish;
    end

endmodule
